// ===== rtl/nbmf_pkg.sv =====
// ----------------------------------------------------------------------------
// nbmf_pkg
// shared types and constants of the nine-bit mark frame receiver
// ----------------------------------------------------------------------------
package nbmf_pkg;

	localparam int MAX_FRAME_DEF  = 256;
	localparam int TIMER_BITS_DEF = 16;

	localparam logic [7:0] ESC_BYTE  = 8'hFF;
	localparam logic [7:0] MARK_BYTE = 8'h00;

	localparam logic [15:0] FIRST_GAP_RST = 16'd5000;
	localparam logic [15:0] INTER_GAP_RST = 16'd1500;
	localparam logic [8:0]  MAX_LEN_RST   = 9'd256;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_GAP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTER_GAP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN   = 2'd2;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic       func;
		logic [7:0] raw_byte;
	} rx_item_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_flag;
		logic       last_flag;
		logic [7:0] position;
		logic       overflow;
		logic       escape_error;
	} frame_item_t;

	typedef enum logic [1:0] {
		PH_PLAIN,
		PH_ESC,
		PH_MARK
	} esc_phase_t;

	typedef enum logic [1:0] {
		EV_TICK,
		EV_SPACE,
		EV_MARK,
		EV_ESC_ERR
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t   kind;
		logic [7:0] data;
	} event_t;

	typedef struct packed {
		logic [15:0] first_gap;
		logic [15:0] inter_gap;
		logic [8:0]  max_len;
	} cfg_t;

endpackage

// ===== rtl/nbmf_decoder.sv =====
// ----------------------------------------------------------------------------
// nbmf_decoder
// front end: undoes the escape coding and classifies each transaction
// ----------------------------------------------------------------------------
module nbmf_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rx_valid,
	output logic              rx_ready,
	input  nbmf_pkg::rx_item_t rx_item,
	output logic              ev_valid,
	input  logic              ev_ready,
	output nbmf_pkg::event_t  ev
);
	import nbmf_pkg::*;

	esc_phase_t phase_q;
	esc_phase_t phase_d;
	logic       fire;

	assign rx_ready = ev_ready;
	assign fire     = rx_valid && rx_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PLAIN;
		end else if (fire) begin
			phase_q <= phase_d;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		ev_valid = 1'b0;
		ev.kind  = EV_TICK;
		ev.data  = rx_item.raw_byte;
		if (rx_item.func) begin
			ev_valid = rx_valid;
		end else begin
			case (phase_q)
				PH_MARK: begin
					phase_d  = PH_PLAIN;
					ev.kind  = EV_MARK;
					ev_valid = rx_valid;
				end
				PH_ESC: begin
					phase_d = PH_PLAIN;
					if (rx_item.raw_byte == MARK_BYTE) begin
						phase_d = PH_MARK;
					end else if (rx_item.raw_byte == ESC_BYTE) begin
						ev.kind  = EV_SPACE;
						ev_valid = rx_valid;
					end else begin
						ev.kind  = EV_ESC_ERR;
						ev_valid = rx_valid;
					end
				end
				default: begin
					if (rx_item.raw_byte == ESC_BYTE) begin
						phase_d = PH_ESC;
					end else begin
						ev.kind  = EV_SPACE;
						ev_valid = rx_valid;
					end
				end
			endcase
		end
	end

endmodule

// ===== rtl/nbmf_fifo.sv =====
// ----------------------------------------------------------------------------
// nbmf_fifo
// short event queue between the decoder and the framer
// ----------------------------------------------------------------------------
module nbmf_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  nbmf_pkg::event_t wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output nbmf_pkg::event_t rd_data
);
	import nbmf_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	event_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;
	logic               pop;

	assign wr_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== rtl/nbmf_framer.sv =====
// ----------------------------------------------------------------------------
// nbmf_framer
// back end: frame delimiting, gap timing, length limit and output register
// ----------------------------------------------------------------------------
module nbmf_framer #(
	parameter int MAX_FRAME  = nbmf_pkg::MAX_FRAME_DEF,
	parameter int TIMER_BITS = nbmf_pkg::TIMER_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  nbmf_pkg::cfg_t        cfg,
	input  logic                  ev_valid,
	output logic                  ev_ready,
	input  nbmf_pkg::event_t      ev,
	output logic                  frame_valid,
	input  logic                  frame_ready,
	output nbmf_pkg::frame_item_t frame_item
);
	import nbmf_pkg::*;

	localparam int CNT_W = $clog2(MAX_FRAME + 1);
	localparam int LEN_W = (CNT_W > 9) ? CNT_W : 9;
	localparam int POS_W = (CNT_W > 8) ? CNT_W : 8;
	localparam int GAP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
	localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

	logic                  in_frame_q, in_frame_d;
	logic [7:0]            held_data_q, held_data_d;
	logic                  held_first_q, held_first_d;
	logic [CNT_W-1:0]      count_q, count_d;
	logic [TIMER_BITS-1:0] timer_q, timer_d;
	logic                  ovf_q, ovf_d;
	logic                  out_valid_q;
	frame_item_t           out_q;

	logic                  fire;
	logic                  emit;
	logic                  emit_last;
	logic                  emit_esc;
	logic [LEN_W-1:0]      len_lim;
	logic [GAP_W-1:0]      gap_lim;
	logic [TIMER_BITS-1:0] timer_inc;
	logic [POS_W-1:0]      pos_full;
	frame_item_t           out_d;

	assign ev_ready    = !out_valid_q || frame_ready;
	assign fire        = ev_valid && ev_ready;
	assign frame_valid = out_valid_q;
	assign frame_item  = out_q;

	always_comb begin
		len_lim = LEN_W'(cfg.max_len);
		if (len_lim == '0) begin
			len_lim = LEN_W'(1);
		end else if (len_lim > LEN_W'(MAX_FRAME)) begin
			len_lim = LEN_W'(MAX_FRAME);
		end
		gap_lim = (count_q <= CNT_W'(1)) ? GAP_W'(cfg.first_gap) : GAP_W'(cfg.inter_gap);
		if (gap_lim == '0) begin
			gap_lim = GAP_W'(1);
		end else if (gap_lim > GAP_W'(TMAX)) begin
			gap_lim = GAP_W'(TMAX);
		end
		timer_inc = (timer_q != TMAX) ? timer_q + 1'b1 : timer_q;
		pos_full  = POS_W'(count_q) - POS_W'(1);
	end

	always_comb begin
		in_frame_d   = in_frame_q;
		held_data_d  = held_data_q;
		held_first_d = held_first_q;
		count_d      = count_q;
		timer_d      = timer_q;
		ovf_d        = ovf_q;
		emit         = 1'b0;
		emit_last    = 1'b0;
		emit_esc     = 1'b0;
		case (ev.kind)
			EV_TICK: begin
				if (in_frame_q) begin
					timer_d = timer_inc;
					if (GAP_W'(timer_inc) >= gap_lim) begin
						emit       = 1'b1;
						emit_last  = 1'b1;
						in_frame_d = 1'b0;
						count_d    = '0;
						timer_d    = '0;
						ovf_d      = 1'b0;
					end
				end
			end
			EV_MARK: begin
				emit         = in_frame_q;
				emit_last    = 1'b1;
				in_frame_d   = 1'b1;
				held_data_d  = ev.data;
				held_first_d = 1'b1;
				count_d      = CNT_W'(1);
				timer_d      = '0;
				ovf_d        = 1'b0;
			end
			EV_ESC_ERR: begin
				if (in_frame_q) begin
					emit         = 1'b1;
					emit_last    = 1'b1;
					emit_esc     = 1'b1;
					in_frame_d   = 1'b0;
					held_first_d = 1'b0;
					count_d      = '0;
					timer_d      = '0;
					ovf_d        = 1'b0;
				end
			end
			default: begin
				if (in_frame_q) begin
					timer_d = '0;
					if (LEN_W'(count_q) >= len_lim) begin
						ovf_d = 1'b1;
					end else begin
						emit         = 1'b1;
						held_data_d  = ev.data;
						held_first_d = 1'b0;
						count_d      = count_q + 1'b1;
					end
				end
			end
		endcase
		out_d.data_byte    = held_data_q;
		out_d.first_flag   = held_first_q;
		out_d.last_flag    = emit_last;
		out_d.position     = pos_full[7:0];
		out_d.overflow     = emit_last && ovf_q;
		out_d.escape_error = emit_esc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			held_first_q <= 1'b0;
			count_q      <= '0;
			timer_q      <= '0;
			ovf_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (fire) begin
				in_frame_q   <= in_frame_d;
				held_first_q <= held_first_d;
				count_q      <= count_d;
				timer_q      <= timer_d;
				ovf_q        <= ovf_d;
			end
			if (fire && emit) begin
				out_valid_q <= 1'b1;
			end else if (frame_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			held_data_q <= held_data_d;
		end
		if (fire && emit) begin
			out_q <= out_d;
		end
	end

endmodule

// ===== rtl/nine_bit_mark_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// nine_bit_mark_frame_receiver
// The receiver takes one transaction per cycle, either a received byte or a
// time tick, and delivers decoded frame bytes with first, last, position,
// overflow and escape error flags. A byte comes out one frame byte late, so
// the final byte of a frame appears when the next mark byte, a gap timeout or
// an escape error arrives. Escape prefix bytes, ticks that do not end a frame
// and bytes outside a frame give no output. The sustained rate is one
// transaction per clock: the escape decoder and the framer each take a new
// transaction as soon as the last is taken, with a two-entry queue between
// them and a registered output, and the input stalls only once the queue
// fills behind a stalled output. Configuration writes are taken every cycle
// and should be made while the receiver is idle.
// ----------------------------------------------------------------------------
module nine_bit_mark_frame_receiver #(
	parameter int MAX_FRAME  = nbmf_pkg::MAX_FRAME_DEF,
	parameter int TIMER_BITS = nbmf_pkg::TIMER_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [nbmf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [15:0]                         cfg_data,
	input  logic                                rx_valid,
	output logic                                rx_ready,
	input  nbmf_pkg::rx_item_t                  rx_item,
	output logic                                frame_valid,
	input  logic                                frame_ready,
	output nbmf_pkg::frame_item_t               frame_item
);
	import nbmf_pkg::*;

	cfg_t   cfg_q;
	logic   dec_valid;
	logic   dec_ready;
	event_t dec_ev;
	logic   q_valid;
	logic   q_ready;
	event_t q_ev;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_gap <= FIRST_GAP_RST;
			cfg_q.inter_gap <= INTER_GAP_RST;
			cfg_q.max_len   <= MAX_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FIRST_GAP: cfg_q.first_gap <= cfg_data;
				CFG_INTER_GAP: cfg_q.inter_gap <= cfg_data;
				CFG_MAX_LEN:   cfg_q.max_len   <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	nbmf_decoder u_decoder (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.rx_item  (rx_item),
		.ev_valid (dec_valid),
		.ev_ready (dec_ready),
		.ev       (dec_ev)
	);

	nbmf_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (dec_valid),
		.wr_ready (dec_ready),
		.wr_data  (dec_ev),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_ev)
	);

	nbmf_framer #(
		.MAX_FRAME  (MAX_FRAME),
		.TIMER_BITS (TIMER_BITS)
	) u_framer (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.ev_valid    (q_valid),
		.ev_ready    (q_ready),
		.ev          (q_ev),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame_item  (frame_item)
	);

endmodule

// ===== tb/nine_bit_mark_frame_receiver_tb.sv =====
// ----------------------------------------------------------------------------
// nine_bit_mark_frame_receiver_tb
// Self-checking bench for the nine-bit mark frame receiver. A class keeps its
// own copy of the escape decoder and framer state, predicts the frame bytes
// for every accepted rx transaction and checks each delivered frame
// transaction in order. The stimulus starts with a short directed sequence
// and then runs random escaped frames mixed with noise under several
// register settings and idle patterns, with one long output hold-off.
// ----------------------------------------------------------------------------
module nine_bit_mark_frame_receiver_tb;

	import nbmf_pkg::*;

	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;
	localparam int unsigned TIMER_MAX = (32'd1 << TIMER_BITS_DEF) - 1;
	localparam int unsigned HOLD_OFF_CYCLES = 300;

	class frame_scoreboard;
		logic [15:0] first_gap;
		logic [15:0] inter_gap;
		logic [8:0]  max_len;
		esc_phase_t  esc_state;
		bit          in_frame;
		bit          held_valid;
		bit          held_first;
		bit          overflow_seen;
		logic [7:0]  held_data;
		int unsigned byte_count;
		int unsigned gap_timer;
		frame_item_t expected_frames[$];
		int unsigned errors;

		function new();
			first_gap = FIRST_GAP_RST;
			inter_gap = INTER_GAP_RST;
			max_len = MAX_LEN_RST;
			esc_state = PH_PLAIN;
			held_data = '0;
			errors = 0;
			close_frame();
		endfunction

		function void close_frame();
			in_frame = 1'b0;
			held_valid = 1'b0;
			held_first = 1'b0;
			byte_count = 0;
			gap_timer = 0;
			overflow_seen = 1'b0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
			case (idx)
			CFG_FIRST_GAP: first_gap = val;
			CFG_INTER_GAP: inter_gap = val;
			CFG_MAX_LEN:   max_len = val[8:0];
			default: ;
			endcase
		endfunction

		function void push_held(bit is_last, bit esc_err);
			frame_item_t f;
			if (!held_valid)
				return;
			f.data_byte = held_data;
			f.first_flag = held_first;
			f.last_flag = is_last;
			f.position = 8'(byte_count - 1);
			f.overflow = is_last && overflow_seen;
			f.escape_error = is_last && esc_err;
			expected_frames.push_back(f);
		endfunction

		function void note_rx(rx_item_t it);
			int unsigned limit;
			int unsigned len_cap;
			if (it.func == FUNC_TICK) begin
				if (!in_frame)
					return;
				if (gap_timer < TIMER_MAX)
					gap_timer++;
				limit = (byte_count <= 1) ? 32'(first_gap) : 32'(inter_gap);
				if (limit == 0)
					limit = 1;
				if (limit > TIMER_MAX)
					limit = TIMER_MAX;
				if (gap_timer >= limit) begin
					push_held(1'b1, 1'b0);
					close_frame();
				end
				return;
			end
			case (esc_state)
			PH_MARK: begin
				esc_state = PH_PLAIN;
				if (in_frame)
					push_held(1'b1, 1'b0);
				in_frame = 1'b1;
				held_valid = 1'b1;
				held_data = it.raw_byte;
				held_first = 1'b1;
				byte_count = 1;
				gap_timer = 0;
				overflow_seen = 1'b0;
				return;
			end
			PH_ESC: begin
				esc_state = PH_PLAIN;
				if (it.raw_byte == MARK_BYTE) begin
					esc_state = PH_MARK;
					return;
				end
				if (it.raw_byte != ESC_BYTE) begin
					if (in_frame) begin
						push_held(1'b1, 1'b1);
						close_frame();
					end
					return;
				end
				// literal ff continues as a space byte
			end
			default: begin
				if (it.raw_byte == ESC_BYTE) begin
					esc_state = PH_ESC;
					return;
				end
			end
			endcase
			if (!in_frame)
				return;
			gap_timer = 0;
			len_cap = (max_len == 0) ? 1 : (max_len > MAX_FRAME_DEF) ? MAX_FRAME_DEF :
				32'(max_len);
			if (byte_count >= len_cap) begin
				overflow_seen = 1'b1;
				return;
			end
			push_held(1'b0, 1'b0);
			held_valid = 1'b1;
			held_data = it.raw_byte;
			held_first = 1'b0;
			byte_count++;
		endfunction

		function void check_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s expected %0h actual %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_frame(frame_item_t got);
			frame_item_t want;
			if (expected_frames.size() == 0) begin
				$error("frame transaction with nothing expected: %p", got);
				errors++;
				return;
			end
			want = expected_frames.pop_front();
			check_field("data_byte", want.data_byte, got.data_byte);
			check_field("first_flag", 8'(want.first_flag), 8'(got.first_flag));
			check_field("last_flag", 8'(want.last_flag), 8'(got.last_flag));
			check_field("position", want.position, got.position);
			check_field("overflow", 8'(want.overflow), 8'(got.overflow));
			check_field("escape_error", 8'(want.escape_error), 8'(got.escape_error));
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_FIRST_GAP;
	logic [15:0]          cfg_data = '0;
	logic                 rx_valid = 1'b0;
	logic                 rx_ready;
	rx_item_t             rx_item = '0;
	logic                 frame_valid;
	logic                 frame_ready = 1'b0;
	frame_item_t          frame_item;

	frame_scoreboard sb = new();
	int unsigned items_sent = 0;
	int unsigned tx_idle_pct = 34;
	int unsigned rx_idle_pct = 61;
	bit          hold_off = 1'b0;
	int unsigned held_cycles = 0;

	nine_bit_mark_frame_receiver u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.rx_valid    (rx_valid),
		.rx_ready    (rx_ready),
		.rx_item     (rx_item),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame_item  (frame_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// output side: random back-pressure plus one long hold-off
	always @(posedge clk) begin
		if (hold_off && held_cycles < HOLD_OFF_CYCLES) begin
			frame_ready <= 1'b0;
			held_cycles <= held_cycles + 1;
		end else
			frame_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (frame_valid && frame_ready)
			sb.check_frame(frame_item);
		if (rx_valid && rx_ready)
			sb.note_rx(rx_item);
		if (cfg_valid && cfg_ready)
			sb.write_reg(cfg_index, cfg_data);
	end

	task automatic send_rx(input logic f, input logic [7:0] b);
		if ($urandom_range(99) < tx_idle_pct) begin
			rx_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_item <= rx_item_t'{func: f, raw_byte: b};
		do @(posedge clk); while (!rx_ready);
		items_sent++;
	endtask

	task automatic send_ticks(input int unsigned count);
		repeat (count) send_rx(FUNC_TICK, 8'($urandom));
	endtask

	task automatic send_frame(input int unsigned n_bytes, input int unsigned tick_max);
		logic [7:0] b;
		send_rx(FUNC_BYTE, ESC_BYTE);
		send_rx(FUNC_BYTE, MARK_BYTE);
		send_rx(FUNC_BYTE, 8'($urandom));
		repeat (n_bytes) begin
			if ($urandom_range(3) == 0)
				send_ticks($urandom_range(0, tick_max));
			b = ($urandom_range(7) == 0) ? ESC_BYTE : 8'($urandom);
			if (b == ESC_BYTE)
				send_rx(FUNC_BYTE, ESC_BYTE);
			send_rx(FUNC_BYTE, b);
		end
		case ($urandom_range(3))
		0: send_ticks(tick_max + 1);
		1: begin
			send_rx(FUNC_BYTE, ESC_BYTE);
			send_rx(FUNC_BYTE, 8'($urandom_range(1, 254)));
		end
		default: ;
		endcase
	endtask

	task automatic send_noise(input int unsigned count);
		repeat (count) begin
			case ($urandom_range(4))
			0: send_rx(FUNC_TICK, 8'($urandom));
			1: send_rx(FUNC_BYTE, ESC_BYTE);
			2: send_rx(FUNC_BYTE, MARK_BYTE);
			default: send_rx(FUNC_BYTE, 8'($urandom));
			endcase
		end
	endtask

	task automatic run_random(input int unsigned target, input int unsigned tick_max);
		int unsigned stop;
		stop = items_sent + target;
		while (items_sent < stop) begin
			if ($urandom_range(99) < 80)
				send_frame($urandom_range(0, 8), tick_max);
			else
				send_noise($urandom_range(1, 4));
		end
	endtask

	// leaves the receiver outside any frame with no escape pending
	task automatic close_stream();
		send_rx(FUNC_BYTE, ESC_BYTE);
		send_rx(FUNC_BYTE, 8'h01);
		send_rx(FUNC_BYTE, ESC_BYTE);
		send_rx(FUNC_BYTE, 8'h01);
	endtask

	task automatic wait_idle();
		rx_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_frames.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] first_gap, input logic [15:0] inter_gap,
			input logic [15:0] max_len);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_FIRST_GAP;
		cfg_data <= first_gap;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_INTER_GAP;
		cfg_data <= inter_gap;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_MAX_LEN;
		cfg_data <= max_len;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(16'd3, 16'd2, 16'd3);
		// tick, space byte and escape error outside a frame
		send_ticks(1);
		send_rx(FUNC_BYTE, MARK_BYTE);
		send_rx(FUNC_BYTE, ESC_BYTE);
		send_rx(FUNC_BYTE, 8'h12);
		// frame with ff as start byte, literal ff, overflow, inter gap timeout
		send_rx(FUNC_BYTE, ESC_BYTE);
		send_rx(FUNC_BYTE, MARK_BYTE);
		send_rx(FUNC_BYTE, ESC_BYTE);
		send_ticks(2);
		send_rx(FUNC_BYTE, 8'h80);
		send_rx(FUNC_BYTE, ESC_BYTE);
		send_rx(FUNC_BYTE, ESC_BYTE);
		send_rx(FUNC_BYTE, 8'h7F);
		send_ticks(2);
		// escape sequence split by ticks, then first gap timeout
		send_rx(FUNC_BYTE, ESC_BYTE);
		send_ticks(1);
		send_rx(FUNC_BYTE, MARK_BYTE);
		send_ticks(1);
		send_rx(FUNC_BYTE, MARK_BYTE);
		send_ticks(3);
		// mark inside a frame, then escape error inside a frame
		send_rx(FUNC_BYTE, ESC_BYTE);
		send_rx(FUNC_BYTE, MARK_BYTE);
		send_rx(FUNC_BYTE, 8'hAA);
		send_rx(FUNC_BYTE, 8'h01);
		send_rx(FUNC_BYTE, ESC_BYTE);
		send_rx(FUNC_BYTE, MARK_BYTE);
		send_rx(FUNC_BYTE, 8'h5A);
		send_rx(FUNC_BYTE, ESC_BYTE);
		send_rx(FUNC_BYTE, 8'h3C);
		wait_idle();

		set_config(16'd1, 16'd1, 16'd1);
		run_random(30, 2);
		close_stream();
		wait_idle();

		// zero length acts as one
		set_config(16'd4, 16'd2, 16'd0);
		run_random(20, 5);
		close_stream();
		wait_idle();

		tx_idle_pct <= 61;
		rx_idle_pct <= 34;
		set_config(16'd5, 16'd3, 16'd6);
		run_random(20, 6);
		close_stream();
		wait_idle();

		set_config(16'hFFFF, 16'hFFFF, 16'd256);
		send_frame(256, 0);
		run_random(10, 3);
		close_stream();
		wait_idle();

		// length above the frame maximum acts as the maximum
		tx_idle_pct <= 0;
		rx_idle_pct <= 0;
		set_config(16'd2, 16'd3, 16'h01FF);
		hold_off <= 1'b1;
		run_random(30, 4);
		close_stream();
		wait_idle();

		if (sb.errors == 0)
			$display("PASS nine_bit_mark_frame_receiver");
		else
			$display("FAIL nine_bit_mark_frame_receiver");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL nine_bit_mark_frame_receiver");
		$finish;
	end

endmodule
